// ----- src/mer_pkg.sv -----
// Shared types and constants for the midpoint ellipse rasteriser.
// Used by the front end, the job queue, the back end and the top level.
package mer_pkg;

  localparam int COORD_BITS = 12;
  localparam int STEP_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * COORD_BITS - 2;
  localparam int DELTA_BITS = 40;
  localparam int DEC_BITS   = 48;
  localparam int MUL_BITS   = SQ_BITS + 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int NUM_RUNS   = 4;

  localparam logic        CMD_START  = 1'b0;
  localparam logic        CMD_STEP   = 1'b1;
  localparam logic        KIND_POINT = 1'b0;
  localparam logic        KIND_SPAN  = 1'b1;
  localparam logic [1:0]  CFG_WIDTH  = 2'd0;
  localparam logic [1:0]  CFG_HEIGHT = 2'd1;
  localparam logic [1:0]  CFG_PITCH  = 2'd2;
  localparam logic [31:0] ALPHA_MASK = 32'hFF00_0000;
  localparam logic [12:0] MAX_SCREEN = 13'd4096;

  typedef enum logic [3:0] {
    F_IDLE,
    F_ST1, F_ST2, F_ST3, F_ST4, F_ST5,
    F_UPD, F_DEC,
    F_SW1, F_SW2, F_SW3, F_SW4, F_SW5
  } front_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] mid_x;
    logic signed [COORD_BITS-1:0] mid_y;
    logic signed [STEP_BITS-1:0]  x;
    logic signed [STEP_BITS-1:0]  y;
    logic                         fill;
    logic                         done;
    logic [31:0]                  color;
  } job_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [14:0] pitch;
  } cfg_t;

endpackage

// ----- src/mer_front.sv -----
// Front end: takes start and step requests, runs the midpoint iteration.
// Depends on mer_pkg; pushes one job per step request while active, unless the colour's alpha byte is zero.
module mer_front import mer_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] radius_x,
  input  logic signed [COORD_BITS-1:0] radius_y,
  input  logic                         fill_mode,
  input  logic [31:0]                  pixel_color,
  input  logic                         job_full,
  output logic                         job_push,
  output job_t                         job
);

  front_state_t state, state_next;

  logic                         active;
  logic                         in_region_two;
  logic                         fill_latched;
  logic [31:0]                  color_latched;
  logic signed [COORD_BITS-1:0] mid_x;
  logic signed [COORD_BITS-1:0] mid_y;
  logic signed [COORD_BITS-1:0] rad_x;
  logic signed [STEP_BITS-1:0]  step_x;
  logic signed [STEP_BITS-1:0]  step_y;
  logic [SQ_BITS-1:0]           rx_squared;
  logic [SQ_BITS-1:0]           ry_squared;
  logic signed [DELTA_BITS-1:0] delta_x;
  logic signed [DELTA_BITS-1:0] delta_y;
  logic signed [DEC_BITS-1:0]   decision;
  logic signed [DEC_BITS-1:0]   prod;
  logic signed [DEC_BITS-1:0]   acc;
  logic signed [DEC_BITS-1:0]   rxry_squared;
  logic                         branch;

  logic                         accept;
  logic                         radii_ok;
  logic                         done;
  logic                         switch_region;
  logic signed [MUL_BITS-1:0]   mul_a;
  logic signed [MUL_BITS-1:0]   mul_b;
  logic signed [2*MUL_BITS-1:0] mul_p;
  logic signed [STEP_BITS-1:0]  step_x_inc;
  logic signed [STEP_BITS-1:0]  step_y_dec;
  logic signed [DELTA_BITS-1:0] two_rx_sq;
  logic signed [DELTA_BITS-1:0] two_ry_sq;
  logic signed [DEC_BITS-1:0]   rx_sq_ext;
  logic signed [DEC_BITS-1:0]   ry_sq_ext;
  logic signed [DEC_BITS-1:0]   dx_ext;
  logic signed [DEC_BITS-1:0]   dy_ext;

  assign accept     = push && !full;
  assign radii_ok   = (radius_x > 0) && (radius_y > 0);
  assign done       = in_region_two && (step_y == '0);
  assign step_x_inc = step_x + STEP_BITS'(1);
  assign step_y_dec = step_y - STEP_BITS'(1);
  assign two_rx_sq  = DELTA_BITS'({rx_squared, 1'b0});
  assign two_ry_sq  = DELTA_BITS'({ry_squared, 1'b0});
  assign rx_sq_ext  = DEC_BITS'(rx_squared);
  assign ry_sq_ext  = DEC_BITS'(ry_squared);
  assign dx_ext     = {{(DEC_BITS-DELTA_BITS){delta_x[DELTA_BITS-1]}}, delta_x};
  assign dy_ext     = {{(DEC_BITS-DELTA_BITS){delta_y[DELTA_BITS-1]}}, delta_y};
  assign switch_region = !in_region_two && !(delta_x < delta_y);

  assign job_push = accept && (command == CMD_STEP) && active
                    && ((color_latched & ALPHA_MASK) != '0);
  assign job.mid_x = mid_x;
  assign job.mid_y = mid_y;
  assign job.x     = step_x;
  assign job.y     = step_y;
  assign job.fill  = fill_latched;
  assign job.done  = done;
  assign job.color = color_latched;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      F_ST1: begin
        mul_a = MUL_BITS'(rad_x);
        mul_b = MUL_BITS'(rad_x);
      end
      F_ST2: begin
        mul_a = MUL_BITS'(step_y);
        mul_b = MUL_BITS'(step_y);
      end
      F_ST3: begin
        mul_a = $signed({4'b0, rx_squared});
        mul_b = MUL_BITS'(step_y);
      end
      F_ST4: begin
        mul_a = $signed({4'b0, rx_squared});
        mul_b = $signed({4'b0, ry_squared});
      end
      F_SW1: begin
        mul_a = MUL_BITS'(step_x);
        mul_b = MUL_BITS'(step_x_inc);
      end
      F_SW2: begin
        mul_a = $signed({4'b0, ry_squared});
        mul_b = $signed(prod[MUL_BITS-1:0]);
      end
      F_SW3: begin
        mul_a = MUL_BITS'(step_y_dec);
        mul_b = MUL_BITS'(step_y_dec);
      end
      F_SW4: begin
        mul_a = $signed({4'b0, rx_squared});
        mul_b = $signed(prod[MUL_BITS-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    full       = 1'b1;
    unique case (state)
      F_IDLE: begin
        full = job_full;
        if (accept) begin
          if (command == CMD_START) begin
            if (radii_ok) begin
              state_next = F_ST1;
            end
          end else if (active && !done) begin
            state_next = F_UPD;
          end
        end
      end
      F_ST1: state_next = F_ST2;
      F_ST2: state_next = F_ST3;
      F_ST3: state_next = F_ST4;
      F_ST4: state_next = F_ST5;
      F_ST5: state_next = F_IDLE;
      F_UPD: state_next = F_DEC;
      F_DEC: state_next = switch_region ? F_SW1 : F_IDLE;
      F_SW1: state_next = F_SW2;
      F_SW2: state_next = F_SW3;
      F_SW3: state_next = F_SW4;
      F_SW4: state_next = F_SW5;
      F_SW5: state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      in_region_two <= 1'b0;
      fill_latched  <= 1'b0;
      color_latched <= '0;
      mid_x         <= '0;
      mid_y         <= '0;
      step_x        <= '0;
      step_y        <= '0;
      rx_squared    <= '0;
      ry_squared    <= '0;
      delta_x       <= '0;
      delta_y       <= '0;
      decision      <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (command == CMD_START) begin
              mid_x         <= center_x;
              mid_y         <= center_y;
              fill_latched  <= fill_mode;
              color_latched <= pixel_color;
              in_region_two <= 1'b0;
              active        <= radii_ok;
              rad_x         <= radius_x;
              step_x        <= '0;
              step_y        <= STEP_BITS'(radius_y);
              delta_x       <= '0;
            end else if (active && done) begin
              active <= 1'b0;
            end
          end
        end
        F_ST1: prod <= mul_p[DEC_BITS-1:0];
        F_ST2: begin
          rx_squared <= prod[SQ_BITS-1:0];
          prod       <= mul_p[DEC_BITS-1:0];
        end
        F_ST3: begin
          ry_squared <= prod[SQ_BITS-1:0];
          prod       <= mul_p[DEC_BITS-1:0];
        end
        F_ST4: begin
          delta_y <= {prod[DELTA_BITS-2:0], 1'b0};
          acc     <= ry_sq_ext - prod + DEC_BITS'(rx_squared >> 2);
          prod    <= mul_p[DEC_BITS-1:0];
        end
        F_ST5: begin
          rxry_squared <= prod;
          decision     <= acc;
        end
        F_UPD: begin
          if (!in_region_two) begin
            branch  <= decision[DEC_BITS-1];
            step_x  <= step_x_inc;
            delta_x <= delta_x + two_ry_sq;
            if (!decision[DEC_BITS-1]) begin
              step_y  <= step_y_dec;
              delta_y <= delta_y - two_rx_sq;
            end
          end else begin
            branch  <= (decision > 0);
            step_y  <= step_y_dec;
            delta_y <= delta_y - two_rx_sq;
            if (!(decision > 0)) begin
              step_x  <= step_x_inc;
              delta_x <= delta_x + two_ry_sq;
            end
          end
        end
        F_DEC: begin
          if (!in_region_two) begin
            if (branch) begin
              decision <= decision + dx_ext + ry_sq_ext;
            end else begin
              decision <= decision + dx_ext - dy_ext + ry_sq_ext;
            end
            if (switch_region) begin
              in_region_two <= 1'b1;
            end
          end else begin
            if (branch) begin
              decision <= decision + rx_sq_ext - dy_ext;
            end else begin
              decision <= decision + dx_ext - dy_ext + rx_sq_ext;
            end
          end
        end
        F_SW1: prod <= mul_p[DEC_BITS-1:0];
        F_SW2: prod <= mul_p[DEC_BITS-1:0];
        F_SW3: begin
          acc  <= prod - rxry_squared;
          prod <= mul_p[DEC_BITS-1:0];
        end
        F_SW4: prod <= mul_p[DEC_BITS-1:0];
        F_SW5: decision <= acc + prod;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/mer_queue.sv -----
// Short job queue between the front end and the back end.
// Depends on mer_pkg for the job type and depth.
module mer_queue import mer_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  input  logic rd_en,
  output job_t rd_data,
  output logic q_full,
  output logic q_empty
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;

  assign q_full  = (count == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (PTR_BITS+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (PTR_BITS+1)'(1);
      end
    end
  end

endmodule

// ----- src/mer_back.sv -----
// Back end: clips the mirrored points or spans of one job and emits them
// with word addresses into the output register. Depends on mer_pkg.
module mer_back import mer_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  job_t        job,
  input  logic        job_empty,
  output logic        job_pop,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [11:0] pos_x,
  output logic [11:0] pos_y,
  output logic [12:0] span_length,
  output logic [23:0] word_address,
  output logic [31:0] out_color,
  output logic        last,
  output logic        finished
);

  localparam int CW = COORD_BITS + 3;

  logic [NUM_RUNS-1:0] mask;
  logic [11:0]         cand_x   [NUM_RUNS];
  logic [11:0]         cand_y   [NUM_RUNS];
  logic [12:0]         cand_len [NUM_RUNS];
  logic                cur_kind;
  logic                cur_done;
  logic [31:0]         cur_color;
  logic                out_valid;

  logic [NUM_RUNS-1:0] new_mask;
  logic [11:0]         new_x    [NUM_RUNS];
  logic [11:0]         new_y    [NUM_RUNS];
  logic [12:0]         new_len  [NUM_RUNS];
  logic [1:0]          sel;
  logic [NUM_RUNS-1:0] mask_left;
  logic                emit;
  logic [12:0]         stride;
  logic [24:0]         row_off;

  assign job_pop = (mask == '0) && !job_empty;
  assign emit    = (mask != '0) && (!out_valid || pop);
  assign empty   = !out_valid;
  assign stride  = cfg.pitch[14:2];

  always_comb begin
    logic [12:0]          w;
    logic [12:0]          h;
    logic signed [CW-1:0] w_max;
    logic signed [CW-1:0] h_lim;
    logic signed [CW-1:0] mx;
    logic signed [CW-1:0] my;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] x0 [NUM_RUNS];
    logic signed [CW-1:0] x1 [NUM_RUNS];
    logic signed [CW-1:0] ry [NUM_RUNS];
    logic signed [CW-1:0] cx0;
    logic signed [CW-1:0] cx1;
    logic signed [CW-1:0] len;
    w     = (cfg.width > MAX_SCREEN) ? MAX_SCREEN : cfg.width;
    h     = (cfg.height > MAX_SCREEN) ? MAX_SCREEN : cfg.height;
    w_max = $signed(CW'(w)) - CW'(1);
    h_lim = $signed(CW'(h));
    mx    = CW'(job.mid_x);
    my    = CW'(job.mid_y);
    ox    = CW'(job.x);
    oy    = CW'(job.y);
    if (job.fill) begin
      x0[0] = mx - ox; x1[0] = mx + ox; ry[0] = my + oy;
      x0[1] = mx - ox; x1[1] = mx + ox; ry[1] = my - oy;
      x0[2] = '0;      x1[2] = -CW'(1); ry[2] = -CW'(1);
      x0[3] = '0;      x1[3] = -CW'(1); ry[3] = -CW'(1);
    end else begin
      x0[0] = mx + ox; x1[0] = mx + ox; ry[0] = my + oy;
      x0[1] = mx - ox; x1[1] = mx - ox; ry[1] = my + oy;
      x0[2] = mx + ox; x1[2] = mx + ox; ry[2] = my - oy;
      x0[3] = mx - ox; x1[3] = mx - ox; ry[3] = my - oy;
    end
    for (int i = 0; i < NUM_RUNS; i++) begin
      cx0 = (x0[i] < 0) ? '0 : x0[i];
      cx1 = (x1[i] > w_max) ? w_max : x1[i];
      len = cx1 - cx0 + CW'(1);
      new_mask[i] = (ry[i] >= 0) && (ry[i] < h_lim) && (cx0 <= cx1);
      new_x[i]    = cx0[11:0];
      new_y[i]    = ry[i][11:0];
      new_len[i]  = len[12:0];
    end
  end

  always_comb begin
    sel = 2'd0;
    for (int i = NUM_RUNS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        sel = 2'(i);
      end
    end
    mask_left      = mask;
    mask_left[sel] = 1'b0;
    row_off        = cand_y[sel] * stride;
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cand_x    <= new_x;
      cand_y    <= new_y;
      cand_len  <= new_len;
      cur_kind  <= job.fill ? KIND_SPAN : KIND_POINT;
      cur_done  <= job.done;
      cur_color <= job.color;
    end
    if (emit) begin
      kind         <= cur_kind;
      pos_x        <= cand_x[sel];
      pos_y        <= cand_y[sel];
      span_length  <= cand_len[sel];
      word_address <= row_off[23:0] + 24'(cand_x[sel]);
      out_color    <= cur_color;
      last         <= (mask_left == '0);
      finished     <= cur_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        mask <= new_mask;
      end else if (emit) begin
        mask <= mask_left;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- src/midpoint_ellipse_rasterizer_core.sv -----
// Midpoint ellipse rasteriser: front end, job queue, back end, config regs.
// A start request runs the setup states F_ST1 to F_ST5 and a step request F_UPD and F_DEC,
// then F_SW1 to F_SW5 on the step that enters region two (shared multiplier sequence); full stays high until F_IDLE.
// The first result of a step passes the queue entry, the back end's candidate registers and
// the output register; while popped, the back end emits one result a cycle through a single address multiplier.
// Reset is synchronous: control state cleared, sizes back to 640x480, pitch 2560.
module midpoint_ellipse_rasterizer_core import mer_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         command,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] radius_x,
  input  logic signed [COORD_BITS-1:0] radius_y,
  input  logic                         fill_mode,
  input  logic [31:0]                  pixel_color,
  output logic                         empty,
  input  logic                         pop,
  output logic                         kind,
  output logic [11:0]                  pos_x,
  output logic [11:0]                  pos_y,
  output logic [12:0]                  span_length,
  output logic [23:0]                  word_address,
  output logic [31:0]                  out_color,
  output logic                         last,
  output logic                         finished,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [14:0]                  cfg_data
);

  cfg_t cfg;
  job_t job_in;
  job_t job_out;
  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 13'd640;
      cfg.height <= 13'd480;
      cfg.pitch  <= 15'd2560;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  cfg.width  <= cfg_data[12:0];
        CFG_HEIGHT: cfg.height <= cfg_data[12:0];
        CFG_PITCH:  cfg.pitch  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mer_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .command     (command),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius_x    (radius_x),
    .radius_y    (radius_y),
    .fill_mode   (fill_mode),
    .pixel_color (pixel_color),
    .job_full    (job_full),
    .job_push    (job_push),
    .job         (job_in)
  );

  mer_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .q_full  (job_full),
    .q_empty (job_empty)
  );

  mer_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .job          (job_out),
    .job_empty    (job_empty),
    .job_pop      (job_pop),
    .empty        (empty),
    .pop          (pop),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .span_length  (span_length),
    .word_address (word_address),
    .out_color    (out_color),
    .last         (last),
    .finished     (finished)
  );

endmodule
